/* sv/kmds_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the key matrix debounce scanner.
// No dependencies; every other file imports this package.
package kmds_pkg;

   localparam int ROWS    = 3;
   localparam int COLS    = 4;
   localparam int ROW_W   = 2;
   localparam int COUNT_W = 8;
   localparam int TICKS_W = 7;

   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [COLS-1:0]    levels_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TICKS_W-1:0] ticks_type;

   localparam ticks_type DEBOUNCE_RESET = ticks_type'(10);
   localparam row_type   LAST_ROW       = row_type'(ROWS - 1);

   // press and release events of one scanned row
   typedef struct packed {
      levels_type press;
      levels_type release_keys;
   } row_event_type;

   // row that follows r, wrapping; an out-of-range row counts as row zero
   function automatic row_type row_after(input row_type r);
      row_type base;
      row_type nxt;
      base = (r > LAST_ROW) ? '0 : r;
      if (base == LAST_ROW) begin
         nxt = '0;
      end else begin
         nxt = base + row_type'(1);
      end
      return nxt;
   endfunction

endpackage

/* sv/kmds_channels.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scanner's request and response sides.
// Depends on kmds_pkg for payload types.
interface kmds_req_if;
   import kmds_pkg::*;
   logic       valid;
   logic       ready;
   levels_type column_levels;

   modport source (output valid, output column_levels, input ready);
   modport sink   (input valid, input column_levels, output ready);
endinterface

interface kmds_rsp_if;
   import kmds_pkg::*;
   logic       valid;
   logic       ready;
   row_type    row_sampled;
   levels_type press_mask;
   levels_type release_mask;
   row_type    next_row;

   modport source (output valid, output row_sampled, output press_mask,
                   output release_mask, output next_row, input ready);
   modport sink   (input valid, input row_sampled, input press_mask,
                   input release_mask, input next_row, output ready);
endinterface

/* sv/kmds_key_logic.sv */
`timescale 1ns / 1ps
// Debounce rule for one key: next count and press/release events.
// Depends on kmds_pkg.
module kmds_key_logic
   import kmds_pkg::*;
(
   input  count_type count,
   input  ticks_type ticks,
   input  logic      level,
   output count_type count_next,
   output logic      press,
   output logic      release_key
);

   count_type ticks_ext;
   count_type count_dec;
   logic      pressed;

   assign ticks_ext = count_type'(ticks);
   assign pressed   = ~level;
   // decrement saturates at zero
   assign count_dec = (count != '0) ? count - count_type'(1) : '0;

   always_comb begin
      count_next  = count;
      press       = 1'b0;
      release_key = 1'b0;
      if (count == '0 && pressed) begin
         count_next = {ticks, 1'b0};
         press      = 1'b1;
      end else if (count == ticks_ext && !pressed) begin
         count_next  = count_dec;
         release_key = 1'b1;
      end else if (count != ticks_ext && count != '0) begin
         count_next = count_dec;
      end
   end

endmodule

/* sv/kmds_count_bank.sv */
`timescale 1ns / 1ps
// Per-key debounce counters for the whole matrix, updated one row at a time.
// Depends on kmds_pkg and kmds_key_logic.
module kmds_count_bank
   import kmds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          update_en,
   input  row_type       row,
   input  levels_type    levels,
   input  ticks_type     ticks,
   output row_event_type events
);

   count_type counts_ff [ROWS][COLS];
   count_type counts_in [COLS];
   count_type row_counts [COLS];
   row_type   row_sel;

   // an out-of-range row is served as row zero
   assign row_sel = (row > LAST_ROW) ? '0 : row;

   for (genvar c = 0; c < COLS; c++) begin : g_col
      assign row_counts[c] = counts_ff[row_sel][c];

      kmds_key_logic u_key (
         .count       (row_counts[c]),
         .ticks       (ticks),
         .level       (levels[c]),
         .count_next  (counts_in[c]),
         .press       (events.press[c]),
         .release_key (events.release_keys[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               counts_ff[r][c] <= '0;
            end
         end
      end else if (update_en) begin
         for (int c = 0; c < COLS; c++) begin
            counts_ff[row_sel][c] <= counts_in[c];
         end
      end
   end

endmodule

/* sv/key_matrix_debounce_scanner.sv */
`timescale 1ns / 1ps
// Key matrix scanner with per-key counter debounce.
// An accepted request is registered in the s1 stage, then in the response registers.
// Throughput: one request per cycle while the response channel is not stalled.
// Reset clears all key counters, returns the scan to row zero and loads a setting of 10.
// Depends on kmds_pkg, kmds_channels and kmds_count_bank.
module key_matrix_debounce_scanner
   import kmds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kmds_req_if.sink   req_chan,
   kmds_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  ticks_type  csr_wr_data
);

   ticks_type     ticks_ff;
   row_type       current_row_ff;
   logic          s1_valid_ff;
   levels_type    s1_levels_ff;
   row_type       s1_row_ff;
   row_type       s1_next_ff;
   logic          rsp_valid_ff;
   row_type       rsp_row_ff;
   levels_type    rsp_press_ff;
   levels_type    rsp_release_ff;
   row_type       rsp_next_ff;
   logic          rsp_load;
   logic          s1_advance;
   logic          req_accept;
   row_event_type events;
   row_type       current_row_in;

   assign rsp_load   = ~rsp_valid_ff | rsp_chan.ready;
   assign s1_advance = s1_valid_ff & rsp_load;
   assign req_chan.ready = ~s1_valid_ff | rsp_load;
   assign req_accept = req_chan.valid & req_chan.ready;
   assign current_row_in = row_after(current_row_ff);

   kmds_count_bank u_bank (
      .clock     (clock),
      .reset     (reset),
      .update_en (s1_advance),
      .row       (s1_row_ff),
      .levels    (s1_levels_ff),
      .ticks     (ticks_ff),
      .events    (events)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff       <= DEBOUNCE_RESET;
         current_row_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ticks_ff <= csr_wr_data;
         end
         // row advances as each request is taken in
         if (req_accept) begin
            current_row_ff <= current_row_in;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_levels_ff <= req_chan.column_levels;
         s1_row_ff    <= current_row_ff;
         s1_next_ff   <= current_row_in;
      end
      if (s1_advance) begin
         rsp_row_ff     <= (s1_row_ff > LAST_ROW) ? '0 : s1_row_ff;
         rsp_press_ff   <= events.press;
         rsp_release_ff <= events.release_keys;
         rsp_next_ff    <= s1_next_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.row_sampled  = rsp_row_ff;
   assign rsp_chan.press_mask   = rsp_press_ff;
   assign rsp_chan.release_mask = rsp_release_ff;
   assign rsp_chan.next_row     = rsp_next_ff;

endmodule
